FILE: rtl/ted_pkg.sv
`default_nettype none
package ted_pkg;

    // coefficient / sensitivity width (Q0.16)
    localparam int COEF_W = 16;
    localparam int CNT_W  = 4;
    localparam int ACT_W  = 16;
    localparam int LVL_W  = 15;

    // config register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SENS    = 2'd2;

    localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd24140;
    localparam logic [COEF_W-1:0] RELEASE_RST = 16'd19;
    localparam logic [COEF_W-1:0] SENS_RST    = 16'd32768;

    // threshold in Q0.32: 0.05 + 0.45 * sens
    localparam int SPAN_W = 31;
    localparam logic [31:0]       THR_BASE = 32'd214748365;
    localparam logic [SPAN_W-1:0] THR_SPAN = 31'd1932735283;

    localparam logic [ACT_W-1:0] ACT_ONE = 16'd32768;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

    typedef struct packed {
        logic load;
        logic step;
        logic first;
    } t_div_ctl;

endpackage
`default_nettype wire

FILE: rtl/ted_mul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle while step is high, MSB first.
module ted_mul #(
    parameter int MCAND_W = 24
) (
    input  wire                                 i_clk,
    input  wire ted_pkg::t_mul_ctl              i_ctl,
    input  wire  [MCAND_W-1:0]                  i_mcand,
    input  wire  [ted_pkg::COEF_W-1:0]          i_mplier,
    output logic [MCAND_W+ted_pkg::COEF_W-1:0]  o_prod
);

    localparam int PW = MCAND_W + ted_pkg::COEF_W;

    logic [MCAND_W-1:0]         r_mcand;
    logic [ted_pkg::COEF_W-1:0] r_mplier;
    logic [PW-1:0]              r_acc;
    logic [PW-1:0]              n_acc;

    always_comb begin
        n_acc = {r_acc[PW-2:0], 1'b0};
        if (r_mplier[ted_pkg::COEF_W-1]) begin
            n_acc = n_acc + PW'(r_mcand);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_acc    <= '0;
        end else if (i_ctl.step) begin
            r_mplier <= {r_mplier[ted_pkg::COEF_W-2:0], 1'b0};
            r_acc    <= n_acc;
        end
    end

    assign o_prod = r_acc;

endmodule
`default_nettype wire

FILE: rtl/ted_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle while step is high. Numerator
// is pre-scaled by the shifts: first step compares unshifted, later steps shift by one.
module ted_div #(
    parameter int W = 24
) (
    input  wire                               i_clk,
    input  wire ted_pkg::t_div_ctl            i_ctl,
    input  wire  [W:0]                        i_num,
    input  wire  [W-1:0]                      i_den,
    output logic [ted_pkg::ACT_W-1:0]         o_quo
);

    logic [W:0]                  r_rem;
    logic [W-1:0]                r_den;
    logic [ted_pkg::ACT_W-1:0]   r_quo;
    logic [W:0]                  w_t;
    logic                        w_ge;

    always_comb begin
        w_t  = i_ctl.first ? r_rem : {r_rem[W-1:0], 1'b0};
        w_ge = (w_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? (w_t - {1'b0, r_den}) : w_t;
            r_quo <= {r_quo[ted_pkg::ACT_W-2:0], w_ge};
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

FILE: rtl/transient_envelope_detector_core.sv
`default_nettype none
// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------------------
// in       | i_in_valid / o_in_ready  | i_sample
// out      | o_out_valid / i_out_ready| o_activity, o_envelope_level
// config   | i_cfg_we                 | i_cfg_addr, i_cfg_data
//
// Envelope above threshold: each item steps through accept, multiply (envelope
// step and threshold side by side), update, compare, divide and output load.
// At or below threshold the divide is skipped.
// A new item is taken while the previous result still waits; its own result then
// holds in the last step until the output register frees up.
// Synchronous active-low reset clears envelope, output valid and FSM, loads coefs.
module transient_envelope_detector_core #(
    parameter int SAMPLE_BITS   = 16,
    parameter int ENV_FRAC_BITS = 23
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [SAMPLE_BITS-1:0]        i_sample,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [ted_pkg::ACT_W-1:0]            o_activity,
    output logic [ted_pkg::LVL_W-1:0]            o_envelope_level,
    input  wire                                  i_cfg_we,
    input  wire  [ted_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire  [ted_pkg::COEF_W-1:0]           i_cfg_data
);

    localparam int EW  = ENV_FRAC_BITS + 1;
    localparam int MW  = SAMPLE_BITS - 1;
    localparam int K   = ENV_FRAC_BITS - MW;
    localparam int SH  = 32 - ENV_FRAC_BITS;
    localparam int CW  = ted_pkg::COEF_W;
    localparam int PW  = EW + CW;
    localparam int TPW = ted_pkg::SPAN_W + CW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic [EW-1:0] ENV_ONE = EW'(1) << ENV_FRAC_BITS;

    logic [2:0]                   r_state;
    logic [ted_pkg::CNT_W-1:0]    r_cnt;
    logic [CW-1:0]                r_att, r_rel, r_sens;
    logic [EW-1:0]                r_env;
    logic [EW-1:0]                r_thr;
    logic                         r_add;
    logic                         r_hit;
    logic                         r_out_valid;
    logic [ted_pkg::ACT_W-1:0]    r_act;
    logic [ted_pkg::LVL_W-1:0]    r_lvl;

    logic                         w_accept;
    logic [SAMPLE_BITS-1:0]       w_neg;
    logic [MW-1:0]                w_mag;
    logic [EW-1:0]                w_mag_e;
    logic [EW-1:0]                w_d;
    logic                         w_gt, w_ge;
    logic [CW-1:0]                w_coef;
    logic [PW-1:0]                w_prod;
    logic [TPW-1:0]               w_tprod;
    logic [PW:0]                  w_step_sum;
    logic [EW:0]                  w_step;
    logic [EW:0]                  w_env_new;
    logic [32:0]                  w_q32;
    logic [32:0]                  w_thr_full;
    logic [ted_pkg::ACT_W-1:0]    w_quo;
    logic [ted_pkg::ACT_W-1:0]    w_act_sat;
    logic                         w_out_load;
    logic                         w_last;
    ted_pkg::t_mul_ctl            w_mul_ctl;
    ted_pkg::t_div_ctl            w_div_ctl;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_last     = (r_cnt == {ted_pkg::CNT_W{1'b1}});

    // magnitude, most negative sample saturates
    always_comb begin
        w_neg = -i_sample;
        if (!i_sample[SAMPLE_BITS-1]) begin
            w_mag = i_sample[MW-1:0];
        end else if (w_neg[SAMPLE_BITS-1]) begin
            w_mag = {MW{1'b1}};
        end else begin
            w_mag = w_neg[MW-1:0];
        end
    end

    generate
        if (K >= 0) begin : g_up
            assign w_mag_e = EW'(w_mag) << K;
        end else begin : g_down
            assign w_mag_e = EW'(w_mag >> (-K));
        end
    endgenerate

    always_comb begin
        w_gt   = (w_mag_e > r_env);
        w_ge   = (w_mag_e >= r_env);
        w_d    = w_ge ? (w_mag_e - r_env) : (r_env - w_mag_e);
        w_coef = w_gt ? r_att : r_rel;
    end

    assign w_mul_ctl.load = w_accept;
    assign w_mul_ctl.step = (r_state == ST_MUL);

    ted_mul #(.MCAND_W(EW)) u_env_mul (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_d),
        .i_mplier (w_coef),
        .o_prod   (w_prod)
    );

    ted_mul #(.MCAND_W(ted_pkg::SPAN_W)) u_thr_mul (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (ted_pkg::THR_SPAN),
        .i_mplier (r_sens),
        .o_prod   (w_tprod)
    );

    // envelope step rounded half up, threshold rounded to nearest
    always_comb begin
        w_step_sum = {1'b0, w_prod} + (PW+1)'(1 << (CW - 1));
        w_step     = w_step_sum[PW:CW];
        w_env_new  = r_add ? ({1'b0, r_env} + w_step) : ({1'b0, r_env} - w_step);
        w_q32      = {1'b0, ted_pkg::THR_BASE} + 33'(w_tprod[TPW-1:CW]);
        w_thr_full = (w_q32 + (33'd1 << (SH - 1))) >> SH;
    end

    assign w_div_ctl.load  = (r_state == ST_CMP);
    assign w_div_ctl.step  = (r_state == ST_DIV);
    assign w_div_ctl.first = (r_cnt == '0);

    ted_div #(.W(EW)) u_div (
        .i_clk   (i_clk),
        .i_ctl   (w_div_ctl),
        .i_num   ({1'b0, r_env - r_thr}),
        .i_den   (ENV_ONE - r_thr),
        .o_quo   (w_quo)
    );

    assign w_act_sat  = (w_quo > ted_pkg::ACT_ONE) ? ted_pkg::ACT_ONE : w_quo;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_att       <= ted_pkg::ATTACK_RST;
            r_rel       <= ted_pkg::RELEASE_RST;
            r_sens      <= ted_pkg::SENS_RST;
            r_env       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ted_pkg::CFG_ATTACK:  r_att  <= i_cfg_data;
                    ted_pkg::CFG_RELEASE: r_rel  <= i_cfg_data;
                    ted_pkg::CFG_SENS:    r_sens <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_MUL;
                        r_cnt   <= '0;
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_env   <= w_env_new[EW-1:0];
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_cnt   <= '0;
                    r_state <= (r_env > r_thr) ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_add <= w_ge;
        end
        if (r_state == ST_UPD) begin
            r_thr <= w_thr_full[EW-1:0];
        end
        if (r_state == ST_CMP) begin
            r_hit <= (r_env > r_thr);
        end
        if (w_out_load) begin
            r_act <= r_hit ? w_act_sat : '0;
            r_lvl <= r_env[ENV_FRAC_BITS-1 -: ted_pkg::LVL_W];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_activity       = r_act;
    assign o_envelope_level = r_lvl;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int SAMPLE_BITS   = 16;
    localparam int ENV_FRAC_BITS = 23;
    localparam int ENV_SHIFT     = ENV_FRAC_BITS - (SAMPLE_BITS - 1);

    // index 3 decodes to nothing; writes there must be dropped
    localparam logic [ted_pkg::CFG_ADDR_W-1:0] CFG_NONE = 2'd3;

    // threshold in Q0.32: 0.05 + 0.45 * sens
    localparam logic [63:0] THR_FLOOR_Q32 = 64'd214748365;
    localparam logic [63:0] THR_RANGE_Q32 = 64'd1932735283;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 175;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic [ted_pkg::ACT_W-1:0] activity;
        logic [ted_pkg::LVL_W-1:0] level;
    } t_env_result;

    class envelope_tracker;
        logic [ted_pkg::COEF_W-1:0] attack_k;
        logic [ted_pkg::COEF_W-1:0] release_k;
        logic [ted_pkg::COEF_W-1:0] sens_k;
        logic [ENV_FRAC_BITS:0]     env_q;
        t_env_result                expected_levels[$];
        int                         errors;

        function new();
            attack_k  = 16'd24140;
            release_k = 16'd19;
            sens_k    = 16'd32768;
            env_q     = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [ted_pkg::CFG_ADDR_W-1:0] idx,
                                logic [ted_pkg::COEF_W-1:0] val);
            case (idx)
                ted_pkg::CFG_ATTACK:  attack_k  = val;
                ted_pkg::CFG_RELEASE: release_k = val;
                ted_pkg::CFG_SENS:    sens_k    = val;
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_BITS-1:0] s);
            int          sv;
            logic [63:0] mag, coeff, env, delta, thr, unity, act;
            t_env_result res;
            sv  = s;
            mag = (sv < 0) ? 64'(-sv) : 64'(sv);
            if (mag > 64'd32767)
                mag = 64'd32767;  // most negative sample saturates
            mag   = mag << ENV_SHIFT;
            env   = 64'(env_q);
            coeff = (mag > env) ? 64'(attack_k) : 64'(release_k);
            if (mag >= env) begin
                delta = mag - env;
                env   = env + ((coeff * delta + 64'd32768) >> 16);
            end else begin
                delta = env - mag;
                env   = env - ((coeff * delta + 64'd32768) >> 16);
            end
            env_q = env[ENV_FRAC_BITS:0];
            env   = 64'(env_q);

            thr = THR_FLOOR_Q32 + ((THR_RANGE_Q32 * 64'(sens_k)) >> 16);
            thr = (thr + (64'd1 << (31 - ENV_FRAC_BITS))) >> (32 - ENV_FRAC_BITS);
            unity = 64'd1 << ENV_FRAC_BITS;
            act   = 64'd0;
            // strict compare: envelope sitting on the threshold reads as zero
            if (env > thr && unity > thr) begin
                act = ((env - thr) << 15) / (unity - thr);
                if (act > 64'd32768)
                    act = 64'd32768;
            end
            res.activity = act[ted_pkg::ACT_W-1:0];
            res.level    = env[ENV_FRAC_BITS-1 -: ted_pkg::LVL_W];
            expected_levels.push_back(res);
        endfunction

        function void check_level(logic [ted_pkg::ACT_W-1:0] act,
                                  logic [ted_pkg::LVL_W-1:0] lvl);
            t_env_result want;
            if (expected_levels.size() == 0) begin
                $error("unexpected item: activity %0d envelope_level %0d", act, lvl);
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            if (act !== want.activity) begin
                $error("activity: expected %0d, got %0d", want.activity, act);
                errors++;
            end
            if (lvl !== want.level) begin
                $error("envelope_level: expected %0d, got %0d", want.level, lvl);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic signed [SAMPLE_BITS-1:0]      i_sample = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [ted_pkg::ACT_W-1:0]          o_activity;
    logic [ted_pkg::LVL_W-1:0]          o_envelope_level;
    logic                               i_cfg_we = 1'b0;
    logic [ted_pkg::CFG_ADDR_W-1:0]     i_cfg_addr = '0;
    logic [ted_pkg::COEF_W-1:0]         i_cfg_data = '0;

    envelope_tracker tracker = new();
    int              cycle_count = 0;
    int              burst_left = 0;
    int              ready_mode = 0;
    int              ready_left = 0;

    transient_envelope_detector_core #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .ENV_FRAC_BITS (ENV_FRAC_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_activity       (o_activity),
        .o_envelope_level (o_envelope_level),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** transient_envelope_detector_core: FAILED **");
            $finish;
        end
    end

    // result check before sample capture: a result never belongs to this edge's item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                tracker.check_level(o_activity, o_envelope_level);
            if (i_in_valid && o_in_ready)
                tracker.take_sample(i_sample);
        end
    end

    // receiver: free-running, random, sparse, or fully stalled stretches
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 4);
            ready_left <= $urandom_range(20, 300);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0, 1:    i_out_ready <= 1'b1;
            2:       i_out_ready <= $urandom_range(0, 1);
            3:       i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= 1'b0;
        endcase
    end

    // called at a falling edge; returns on a falling edge once the item is taken, after an idle gap unless in a burst
    task automatic push(input logic signed [SAMPLE_BITS-1:0] s);
        int gap;
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 45);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(0, 30);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [ted_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [ted_pkg::COEF_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        tracker.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [ted_pkg::COEF_W-1:0] atk,
                                 input logic [ted_pkg::COEF_W-1:0] rel,
                                 input logic [ted_pkg::COEF_W-1:0] sens);
        settle();
        cfg_write(CFG_NONE, ted_pkg::COEF_W'($urandom));
        cfg_write(ted_pkg::CFG_ATTACK, atk);
        cfg_write(ted_pkg::CFG_RELEASE, rel);
        cfg_write(ted_pkg::CFG_SENS, sens);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // segments of bounded loudness so the envelope climbs and decays
    task automatic run_random(input int count);
        int sent;
        int amp;
        int seg;
        int sv;
        logic signed [SAMPLE_BITS-1:0] s;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 4))
                0:       amp = 32767;
                1:       amp = $urandom_range(0, 32767);
                2:       amp = $urandom_range(0, 512);
                3:       amp = 0;
                default: amp = $urandom_range(16384, 32767);
            endcase
            seg = $urandom_range(4, 40);
            while (seg > 0 && sent < count) begin
                case ($urandom_range(0, 9))
                    0: s = SAMPLE_BITS'($urandom);
                    1: begin
                        case ($urandom_range(0, 3))
                            0:       s = 16'sh8000;
                            1:       s = 16'sh7FFF;
                            2:       s = '0;
                            default: s = '1;
                        endcase
                    end
                    default: begin
                        sv = int'($urandom_range(0, 2 * amp)) - amp;
                        s  = sv[SAMPLE_BITS-1:0];
                    end
                endcase
                push(s);
                sent++;
                seg--;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset coefficients: extremes, sign changes, full-scale rise and decay
        push(16'sd0);
        push(16'sh7FFF);
        push(16'sh7FFF);
        push(16'sh7FFF);
        push(16'sh8000);
        push(16'sh8000);
        push(-16'sd1);
        push(16'sd1);
        push(-16'sd16384);
        push(16'sd16384);
        push(16'sd21845);
        push(-16'sd21846);

        // full release wipes the envelope to zero
        apply_setting(16'd24140, 16'd65535, 16'd32768);
        while (tracker.env_q != '0)
            push(16'sd0);

        // from zero this lands exactly on the sens=0 threshold, then climbs past it
        apply_setting(16'd3840, 16'd65535, 16'd0);
        push(16'sd27962);
        push(16'sd27962);

        // highest threshold with instant attack
        apply_setting(16'd65535, 16'd65535, 16'd65535);
        push(16'sh7FFF);
        push(16'sh8000);
        push(16'sd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_setting(16'd24140, 16'd19, 16'd32768);
                1: apply_setting(16'd65535, 16'd65535, 16'd0);
                2: apply_setting(16'd0, 16'd0, 16'd65535);
                3: apply_setting(16'd65535, 16'd0, 16'd65535);
                4: apply_setting(16'd0, 16'd65535, 16'd0);
                default: apply_setting(ted_pkg::COEF_W'($urandom),
                                       ted_pkg::COEF_W'($urandom),
                                       ted_pkg::COEF_W'($urandom));
            endcase
            run_random(PHASE_ITEMS);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("** transient_envelope_detector_core: PASSED **");
        else
            $display("** transient_envelope_detector_core: FAILED **");
        $finish;
    end

endmodule

FILE: transient_envelope_detector_core.f
rtl/ted_pkg.sv
rtl/ted_mul.sv
rtl/ted_div.sv
rtl/transient_envelope_detector_core.sv
bench/tb_top.sv
